@@ src/ftfb_pkg.sv @@
// ----------------------------------------------------------------------------
// ftfb_pkg: shared definitions for the frame transpose / flip buffer
// Command and mode codes, register indexes, and the control part of a queued
// operation that passes from the front to the back.
// ----------------------------------------------------------------------------
package ftfb_pkg;

   // Command codes on the request channel
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_PULL = 1'b1;

   // Readout modes
   localparam logic MODE_TRANSPOSE = 1'b0;
   localparam logic MODE_FLIP      = 1'b1;

   // Register port layout
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 7;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MODE         = 2'd2;

   // Operation queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;
   localparam int QCNT_BITS   = 3;

   typedef enum logic {
      OP_WRITE,
      OP_LINE
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic        vertical;   // line walks down a column (stride of one row)
      logic        last_line;  // line is the final one of the frame
   } op_ctrl_type;

endpackage

@@ src/frame_transpose_flip_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// A pushed sample enters the operation queue and reaches the frame store when
// the back end pops it; a pulled line passes the queue, walker, read stage and
// output register, its samples following one per cycle while rsp_stall is low.
// One push per cycle while the queue has room; the back end takes no new
// operation until the current line is issued. Reset clears positions, progress
// and queues, sets width 1, height 1, transpose; the store is not cleared.
// ----------------------------------------------------------------------------
// frame_transpose_flip_buffer_unit: frame buffer with transposed or flipped
// readout. Holds the configuration registers and joins the request front,
// the operation queue and the store back end.
// ----------------------------------------------------------------------------
module frame_transpose_flip_buffer_unit
   import ftfb_pkg::*;
#(
   parameter int MAX_DIM     = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_command,
   input  logic [31:0]               req_sample_in,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [31:0]               rsp_sample_out,
   output logic                      rsp_line_last,
   output logic                      rsp_frame_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int CNT_BITS   = $clog2(MAX_DIM + 1);
   localparam int ADDR_BITS  = $clog2(MAX_DIM * MAX_DIM);
   localparam int ENTRY_BITS = $bits(op_ctrl_type) + ADDR_BITS + SAMPLE_BITS + CNT_BITS;

   logic [CSR_DATA_BITS-1:0] width_ff, width_in;
   logic [CSR_DATA_BITS-1:0] height_ff, height_in;
   logic                     mode_ff, mode_in;
   logic [CNT_BITS-1:0]      width_eff;
   logic [CNT_BITS-1:0]      height_eff;

   logic                   ent_valid;
   logic                   ent_ready;
   op_ctrl_type            ent_ctrl;
   logic [ADDR_BITS-1:0]   ent_addr;
   logic [SAMPLE_BITS-1:0] ent_data;
   logic [CNT_BITS-1:0]    ent_len;
   logic [ENTRY_BITS-1:0]  ent_packed;

   logic                   q_valid;
   logic                   q_pop;
   logic [ENTRY_BITS-1:0]  q_packed;
   op_ctrl_type            q_ctrl;
   logic [ADDR_BITS-1:0]   q_addr;
   logic [SAMPLE_BITS-1:0] q_data;
   logic [CNT_BITS-1:0]    q_len;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      mode_in   = mode_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_FRAME_WIDTH:  width_in  = csr_data;
            REG_FRAME_HEIGHT: height_in = csr_data;
            REG_MODE:         mode_in   = csr_data[0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_DATA_BITS'(1);
         height_ff <= CSR_DATA_BITS'(1);
         mode_ff   <= MODE_TRANSPOSE;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         mode_ff   <= mode_in;
      end
   end

   // Clamp dimensions to 1..MAX_DIM
   always_comb begin
      if (width_ff == '0) begin
         width_eff = CNT_BITS'(1);
      end else if (width_ff > CSR_DATA_BITS'(MAX_DIM)) begin
         width_eff = CNT_BITS'(MAX_DIM);
      end else begin
         width_eff = width_ff[CNT_BITS-1:0];
      end
      if (height_ff == '0) begin
         height_eff = CNT_BITS'(1);
      end else if (height_ff > CSR_DATA_BITS'(MAX_DIM)) begin
         height_eff = CNT_BITS'(MAX_DIM);
      end else begin
         height_eff = height_ff[CNT_BITS-1:0];
      end
   end

   ftfb_front #(
      .MAX_DIM     (MAX_DIM),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_sample_in (req_sample_in),
      .cfg_width     (width_eff),
      .cfg_height    (height_eff),
      .cfg_mode      (mode_ff),
      .ent_valid     (ent_valid),
      .ent_ready     (ent_ready),
      .ent_ctrl      (ent_ctrl),
      .ent_addr      (ent_addr),
      .ent_data      (ent_data),
      .ent_len       (ent_len)
   );

   // Pack and unpack queued operations
   assign ent_packed = {ent_ctrl, ent_addr, ent_data, ent_len};
   assign {q_ctrl, q_addr, q_data, q_len} = q_packed;

   ftfb_queue #(
      .ENTRY_BITS (ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ent_valid),
      .in_ready  (ent_ready),
      .in_entry  (ent_packed),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_entry (q_packed)
   );

   ftfb_back #(
      .MAX_DIM     (MAX_DIM),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_ctrl         (q_ctrl),
      .q_addr         (q_addr),
      .q_data         (q_data),
      .q_len          (q_len),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_line_last  (rsp_line_last),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

@@ src/ftfb_front.sv @@
// ----------------------------------------------------------------------------
// ftfb_front: request intake and classification
// Tracks the write position and the readout progress of the frame, turns
// pushes into store writes and pulls into line operations, and drops the
// commands that do nothing in the current state.
// ----------------------------------------------------------------------------
module ftfb_front
   import ftfb_pkg::*;
#(
   parameter int MAX_DIM     = 64,
   parameter int SAMPLE_BITS = 32,
   localparam int IDX_BITS   = $clog2(MAX_DIM),
   localparam int CNT_BITS   = $clog2(MAX_DIM + 1),
   localparam int ADDR_BITS  = $clog2(MAX_DIM * MAX_DIM)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_command,
   input  logic [31:0]            req_sample_in,
   input  logic [CNT_BITS-1:0]    cfg_width,
   input  logic [CNT_BITS-1:0]    cfg_height,
   input  logic                   cfg_mode,
   output logic                   ent_valid,
   input  logic                   ent_ready,
   output op_ctrl_type            ent_ctrl,
   output logic [ADDR_BITS-1:0]   ent_addr,
   output logic [SAMPLE_BITS-1:0] ent_data,
   output logic [CNT_BITS-1:0]    ent_len
);

   logic [IDX_BITS-1:0] wcol_ff, wcol_in;
   logic [IDX_BITS-1:0] wrow_ff, wrow_in;
   logic [IDX_BITS-1:0] lines_ff, lines_in;
   logic                full_ff, full_in;

   logic                accept;
   logic [CNT_BITS-1:0] col_next;
   logic [CNT_BITS-1:0] row_next;
   logic [CNT_BITS-1:0] lines_next;
   logic [CNT_BITS-1:0] total_lines;
   logic [CNT_BITS-1:0] line_len;
   logic [CNT_BITS-1:0] flip_row;
   logic                has_line;
   logic                last_line;
   logic [IDX_BITS-1:0] row_sel;
   logic [IDX_BITS-1:0] col_sel;
   logic [63:0]         sample_wide;

   // Take a beat whenever the queue has room
   assign req_stall = !ent_ready;
   assign accept    = req_valid && ent_ready;

   // Position arithmetic
   assign col_next    = CNT_BITS'(wcol_ff) + CNT_BITS'(1);
   assign row_next    = CNT_BITS'(wrow_ff) + CNT_BITS'(1);
   assign lines_next  = CNT_BITS'(lines_ff) + CNT_BITS'(1);
   assign total_lines = (cfg_mode == MODE_TRANSPOSE) ? cfg_width : cfg_height;
   assign line_len    = (cfg_mode == MODE_TRANSPOSE) ? cfg_height : cfg_width;
   assign has_line    = CNT_BITS'(lines_ff) < total_lines;
   assign last_line   = lines_next >= total_lines;
   assign flip_row    = cfg_height - CNT_BITS'(1) - CNT_BITS'(lines_ff);

   // Store address: write position for a push, first sample of the line for a pull
   always_comb begin
      if (req_command == CMD_PUSH) begin
         row_sel = wrow_ff;
         col_sel = wcol_ff;
      end else if (cfg_mode == MODE_TRANSPOSE) begin
         row_sel = '0;
         col_sel = lines_ff;
      end else begin
         row_sel = flip_row[IDX_BITS-1:0];
         col_sel = '0;
      end
   end

   assign ent_addr    = ADDR_BITS'(row_sel) * ADDR_BITS'(MAX_DIM) + ADDR_BITS'(col_sel);
   assign sample_wide = {32'd0, req_sample_in};
   assign ent_data    = sample_wide[SAMPLE_BITS-1:0];
   assign ent_len     = line_len;

   // Classify the beat and advance the frame position
   always_comb begin
      wcol_in            = wcol_ff;
      wrow_in            = wrow_ff;
      lines_in           = lines_ff;
      full_in            = full_ff;
      ent_valid          = 1'b0;
      ent_ctrl.kind      = OP_WRITE;
      ent_ctrl.vertical  = (cfg_mode == MODE_TRANSPOSE);
      ent_ctrl.last_line = last_line;
      if (accept) begin
         if (req_command == CMD_PUSH) begin
            if (!full_ff) begin
               ent_valid = 1'b1;
               if (col_next >= cfg_width) begin
                  wcol_in = '0;
                  wrow_in = row_next[IDX_BITS-1:0];
                  if (row_next >= cfg_height) begin
                     full_in = 1'b1;
                  end
               end else begin
                  wcol_in = col_next[IDX_BITS-1:0];
               end
            end
         end else if (full_ff) begin
            if (has_line) begin
               ent_valid     = 1'b1;
               ent_ctrl.kind = OP_LINE;
               lines_in      = lines_next[IDX_BITS-1:0];
            end
            // Frame done, or nothing left after a shrink: back to collecting
            if (!has_line || last_line) begin
               wcol_in  = '0;
               wrow_in  = '0;
               lines_in = '0;
               full_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wcol_ff  <= '0;
         wrow_ff  <= '0;
         lines_ff <= '0;
         full_ff  <= 1'b0;
      end else begin
         wcol_ff  <= wcol_in;
         wrow_ff  <= wrow_in;
         lines_ff <= lines_in;
         full_ff  <= full_in;
      end
   end

endmodule

@@ src/ftfb_queue.sv @@
// ----------------------------------------------------------------------------
// ftfb_queue: short operation queue
// First-in first-out buffer of packed operations between the front and the
// back, so each side can stall without holding the other.
// ----------------------------------------------------------------------------
module ftfb_queue
   import ftfb_pkg::*;
#(
   parameter int ENTRY_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [ENTRY_BITS-1:0] in_entry,
   output logic                  out_valid,
   input  logic                  out_pop,
   output logic [ENTRY_BITS-1:0] out_entry
);

   logic [ENTRY_BITS-1:0] slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  head_ff, head_in;
   logic [QPTR_BITS-1:0]  tail_ff, tail_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign in_ready  = count_ff != QCNT_BITS'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_entry = slot_ff[head_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   // Advance pointers and occupancy
   always_comb begin
      head_in  = pop ? head_ff + QPTR_BITS'(1) : head_ff;
      tail_in  = push ? tail_ff + QPTR_BITS'(1) : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Store the incoming operation
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= in_entry;
      end
   end

   // Occupancy stays within the slots
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("operation queue over capacity");

   // Pointers and count agree
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QCNT_BITS'(QUEUE_DEPTH)) |-> head_ff == tail_ff)
      else $error("operation queue pointers disagree with count");

endmodule

@@ src/ftfb_back.sv @@
// ----------------------------------------------------------------------------
// ftfb_back: frame store and line readout
// Executes queued operations in order: writes samples into the frame store,
// and walks a line through the store, one sample per cycle while rsp_stall is
// low, through a read stage and an output register that holds under stall.
// ----------------------------------------------------------------------------
module ftfb_back
   import ftfb_pkg::*;
#(
   parameter int MAX_DIM     = 64,
   parameter int SAMPLE_BITS = 32,
   localparam int CNT_BITS   = $clog2(MAX_DIM + 1),
   localparam int ADDR_BITS  = $clog2(MAX_DIM * MAX_DIM),
   localparam int DEPTH      = MAX_DIM * MAX_DIM
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_pop,
   input  op_ctrl_type            q_ctrl,
   input  logic [ADDR_BITS-1:0]   q_addr,
   input  logic [SAMPLE_BITS-1:0] q_data,
   input  logic [CNT_BITS-1:0]    q_len,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [31:0]            rsp_sample_out,
   output logic                   rsp_line_last,
   output logic                   rsp_frame_last
);

   logic [SAMPLE_BITS-1:0] store [DEPTH];

   // Line walker
   logic                 active_ff, active_in;
   logic [ADDR_BITS-1:0] cursor_ff, cursor_in;
   logic [CNT_BITS-1:0]  remain_ff, remain_in;
   logic                 vert_ff, vert_in;
   logic                 last_ff, last_in;

   // Read stage
   logic                   rd_valid_ff, rd_valid_in;
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic                   rd_line_last_ff;
   logic                   rd_frame_last_ff;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff;
   logic        rsp_line_last_ff;
   logic        rsp_frame_last_ff;

   logic                 out_free;
   logic                 rd_move;
   logic                 rd_free;
   logic                 issue;
   logic                 issue_end;
   logic                 wr_en;
   logic                 load;
   logic [ADDR_BITS-1:0] stride;
   logic [63:0]          rd_wide;

   // Handshake through the two stages
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rd_move   = rd_valid_ff && out_free;
   assign rd_free   = !rd_valid_ff || rd_move;
   assign issue     = active_ff && rd_free;
   assign issue_end = remain_ff == CNT_BITS'(1);

   // Take the next operation once the current line is fully issued
   assign q_pop = q_valid && !active_ff;
   assign wr_en = q_pop && (q_ctrl.kind == OP_WRITE);
   assign load  = q_pop && (q_ctrl.kind == OP_LINE);

   assign stride = vert_ff ? ADDR_BITS'(MAX_DIM) : ADDR_BITS'(1);

   // Walker next state
   always_comb begin
      active_in = active_ff;
      cursor_in = cursor_ff;
      remain_in = remain_ff;
      vert_in   = vert_ff;
      last_in   = last_ff;
      if (load) begin
         active_in = 1'b1;
         cursor_in = q_addr;
         remain_in = q_len;
         vert_in   = q_ctrl.vertical;
         last_in   = q_ctrl.last_line;
      end else if (issue) begin
         cursor_in = cursor_ff + stride;
         remain_in = remain_ff - CNT_BITS'(1);
         if (issue_end) begin
            active_in = 1'b0;
         end
      end
   end

   always_comb begin
      rd_valid_in = rd_valid_ff;
      if (issue) begin
         rd_valid_in = 1'b1;
      end else if (rd_move) begin
         rd_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rd_move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      remain_ff <= remain_in;
      vert_ff   <= vert_in;
      last_ff   <= last_in;
   end

   // Frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[q_addr] <= q_data;
      end
      if (issue) begin
         rd_data_ff <= store[cursor_ff];
      end
   end

   // Tag the read with its line and frame end marks
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_line_last_ff  <= issue_end;
         rd_frame_last_ff <= issue_end && last_ff;
      end
   end

   // Load the output register
   assign rd_wide = 64'(rd_data_ff);

   always_ff @(posedge clock) begin
      if (rd_move) begin
         rsp_data_ff       <= rd_wide[31:0];
         rsp_line_last_ff  <= rd_line_last_ff;
         rsp_frame_last_ff <= rd_frame_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;
   assign rsp_line_last  = rsp_line_last_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

   // Frame end only on a line end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_frame_last_ff |-> rsp_line_last_ff)
      else $error("frame end without line end");

   // An active line always has samples left to issue
   assert property (@(posedge clock) disable iff (reset)
      active_ff |-> remain_ff != '0)
      else $error("active line with no samples left");

   // A blocked read stage holds its sample
   assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff && !rd_move |=> rd_valid_ff && $stable(rd_data_ff))
      else $error("read stage lost a held sample");

endmodule
